// ----- sv/cdbp_pkg.sv -----
// shared types and constants of the cascade dual block parity engine
package cdbp_pkg;

   localparam int RANGE_W  = 13;
   localparam int ADDR_W   = 12;
   localparam int PASS_W   = 8;
   localparam int WORD_W   = 32;
   localparam int WORD_LOG = 5;
   localparam int IDX_W    = RANGE_W - WORD_LOG;

   localparam logic [PASS_W-1:0] PASS_MAX = '1;

   typedef enum logic [1:0] {
      CMD_LOAD  = 2'd0,
      CMD_OPEN  = 2'd1,
      CMD_RESP  = 2'd2,
      CMD_END   = 2'd3
   } cmd_type;

   typedef struct packed {
      cmd_type              cmd;
      logic [ADDR_W-1:0]    key_addr;
      logic                 key_value;
      logic [RANGE_W-1:0]   range_low;
      logic [RANGE_W-1:0]   range_high;
      logic                 left_mismatch;
      logic                 right_mismatch;
   } req_payload_type;

   typedef struct packed {
      logic [RANGE_W-1:0]   msg_low;
      logic [RANGE_W-1:0]   msg_high;
      logic                 left_parity;
      logic                 right_parity;
      logic [PASS_W-1:0]    pass_number;
      logic                 last_of_run;
   } rsp_payload_type;

endpackage

// ----- sv/cdbp_if.sv -----
// valid/ready channels for request and response beats
interface cdbp_req_if;
   logic                      valid;
   logic                      ready;
   cdbp_pkg::req_payload_type data;

   modport source (output valid, output data, input ready);
   modport sink   (input valid, input data, output ready);
endinterface

interface cdbp_rsp_if;
   logic                      valid;
   logic                      ready;
   cdbp_pkg::rsp_payload_type data;

   modport source (output valid, output data, input ready);
   modport sink   (input valid, input data, output ready);
endinterface

// ----- sv/cascade_dual_block_parity.sv -----
// load: read-modify-write of one key word in states LOAD_RD and LOAD_WR
// open: the walk reads each 32-bit key word touched by the left half, then
// each 32-bit key word touched by the right half, and then sends the response
// one word of the key store is read per cycle; one item is worked at a time
// reset clears the sequencer, the output valid flag and the pass count;
// the key store is not cleared and holds garbage until written
module cascade_dual_block_parity #(
   parameter int KEY_BITS = 4096
) (
   input  logic              clock,
   input  logic              reset,
   cdbp_req_if.sink          req_bus,
   cdbp_rsp_if.source        rsp_bus
);

   localparam int WORDS = (KEY_BITS + cdbp_pkg::WORD_W - 1) / cdbp_pkg::WORD_W;
   localparam int AW    = (WORDS > 1) ? $clog2(WORDS) : 1;
   localparam logic [31:0] KEY_LIM = 32'(KEY_BITS);
   localparam logic [cdbp_pkg::RANGE_W-1:0] KEY_LIM_R = cdbp_pkg::RANGE_W'(KEY_BITS);

   typedef enum logic [6:0] {
      ST_IDLE      = 7'b0000001,
      ST_LOAD_RD   = 7'b0000010,
      ST_LOAD_WR   = 7'b0000100,
      ST_HALF_INIT = 7'b0001000,
      ST_WALK      = 7'b0010000,
      ST_DRAIN     = 7'b0100000,
      ST_SEND      = 7'b1000000
   } state_type;

   state_type                          state_ff, state_in;
   logic [cdbp_pkg::PASS_W-1:0]        pass_ff, pass_in;
   logic [cdbp_pkg::ADDR_W-1:0]        ld_addr_ff, ld_addr_in;
   logic                               ld_val_ff, ld_val_in;
   logic [cdbp_pkg::RANGE_W-1:0]       mlo_ff, mlo_in, mhi_ff, mhi_in;
   logic [cdbp_pkg::RANGE_W-1:0]       sec_lo_ff, sec_lo_in, sec_hi_ff, sec_hi_in;
   logic                               last_ff, last_in;
   logic                               sec_pend_ff, sec_pend_in;
   logic                               half_ff, half_in;
   logic                               lpar_ff, lpar_in, rpar_ff, rpar_in;
   logic [cdbp_pkg::IDX_W-1:0]         cur_ff, cur_in, first_ff, first_in;
   logic [cdbp_pkg::IDX_W-1:0]         end_ff, end_in, vidx_ff, vidx_in;
   logic [cdbp_pkg::WORD_LOG-1:0]      lob_ff, lob_in, hib_ff, hib_in;
   logic                               acc_ff, acc_in;
   logic                               vld_ff, vld_in;
   logic                               out_valid_ff, out_valid_in;
   cdbp_pkg::rsp_payload_type          out_ff, out_in;
   logic [cdbp_pkg::WORD_W-1:0]        rd_ff;

   logic [cdbp_pkg::WORD_W-1:0]        key_mem [WORDS];

   logic [cdbp_pkg::RANGE_W-1:0]       mmid, h_lo, h_hi, h_hi_lim, h_last, req_mid;
   logic                               h_empty;
   logic [cdbp_pkg::WORD_W-1:0]        lo_mask, hi_mask, wr_word;
   logic                               word_par;
   logic [31:0]                        word_sel;
   logic [AW-1:0]                      mem_addr;
   logic                               load_phase;
   cdbp_pkg::req_payload_type          req;

   assign req = req_bus.data;

   // split points of the current message and the incoming range
   assign mmid    = cdbp_pkg::RANGE_W'(({1'b0, mlo_ff} + {1'b0, mhi_ff}) >> 1);
   assign req_mid = cdbp_pkg::RANGE_W'(({1'b0, req.range_low} + {1'b0, req.range_high}) >> 1);

   // bounds of the half being walked, clipped to the store
   assign h_lo     = half_ff ? mmid : mlo_ff;
   assign h_hi     = half_ff ? mhi_ff : mmid;
   assign h_hi_lim = ({19'd0, h_hi} > KEY_LIM) ? KEY_LIM_R : h_hi;
   assign h_empty  = (h_lo >= h_hi_lim);
   assign h_last   = h_hi_lim - cdbp_pkg::RANGE_W'(1);

   // edge masks and parity of the word read last cycle
   assign lo_mask  = (vidx_ff == first_ff) ? ({cdbp_pkg::WORD_W{1'b1}} << lob_ff)
                                           : {cdbp_pkg::WORD_W{1'b1}};
   assign hi_mask  = (vidx_ff == end_ff)
                   ? ({cdbp_pkg::WORD_W{1'b1}} >> (cdbp_pkg::WORD_LOG'(31) - hib_ff))
                   : {cdbp_pkg::WORD_W{1'b1}};
   assign word_par = ^(rd_ff & lo_mask & hi_mask);

   // key store address: load word during read-modify-write, else walk index
   assign load_phase = (state_ff == ST_LOAD_RD) || (state_ff == ST_LOAD_WR);
   assign word_sel   = load_phase ? 32'(ld_addr_ff[cdbp_pkg::ADDR_W-1:cdbp_pkg::WORD_LOG])
                                  : 32'(cur_ff);
   assign mem_addr   = word_sel[AW-1:0];
   assign wr_word    = (rd_ff & ~(32'd1 << ld_addr_ff[cdbp_pkg::WORD_LOG-1:0]))
                     | (32'(ld_val_ff) << ld_addr_ff[cdbp_pkg::WORD_LOG-1:0]);

   // key store, one word port
   always_ff @(posedge clock) begin
      if (state_ff == ST_LOAD_WR) begin
         key_mem[mem_addr] <= wr_word;
      end
      rd_ff <= key_mem[mem_addr];
   end

   // sequencer
   always_comb begin
      state_in     = state_ff;
      pass_in      = pass_ff;
      ld_addr_in   = ld_addr_ff;
      ld_val_in    = ld_val_ff;
      mlo_in       = mlo_ff;
      mhi_in       = mhi_ff;
      sec_lo_in    = sec_lo_ff;
      sec_hi_in    = sec_hi_ff;
      last_in      = last_ff;
      sec_pend_in  = sec_pend_ff;
      half_in      = half_ff;
      lpar_in      = lpar_ff;
      rpar_in      = rpar_ff;
      cur_in       = cur_ff;
      first_in     = first_ff;
      end_in       = end_ff;
      lob_in       = lob_ff;
      hib_in       = hib_ff;
      acc_in       = acc_ff;
      vld_in       = 1'b0;
      vidx_in      = vidx_ff;
      out_valid_in = out_valid_ff;
      out_in       = out_ff;

      if (out_valid_ff && rsp_bus.ready) begin
         out_valid_in = 1'b0;
      end

      unique case (state_ff)
         ST_IDLE: begin
            if (req_bus.valid) begin
               unique case (req.cmd)
                  cdbp_pkg::CMD_LOAD: begin
                     if ({20'd0, req.key_addr} < KEY_LIM) begin
                        ld_addr_in = req.key_addr;
                        ld_val_in  = req.key_value;
                        state_in   = ST_LOAD_RD;
                     end
                  end
                  cdbp_pkg::CMD_OPEN: begin
                     mlo_in      = req.range_low;
                     mhi_in      = req.range_high;
                     last_in     = 1'b1;
                     sec_pend_in = 1'b0;
                     half_in     = 1'b0;
                     state_in    = ST_HALF_INIT;
                  end
                  cdbp_pkg::CMD_RESP: begin
                     half_in     = 1'b0;
                     sec_lo_in   = req_mid;
                     sec_hi_in   = req.range_high;
                     if (req.left_mismatch) begin
                        mlo_in      = req.range_low;
                        mhi_in      = req_mid;
                        last_in     = !req.right_mismatch;
                        sec_pend_in = req.right_mismatch;
                        state_in    = ST_HALF_INIT;
                     end else if (req.right_mismatch) begin
                        mlo_in      = req_mid;
                        mhi_in      = req.range_high;
                        last_in     = 1'b1;
                        sec_pend_in = 1'b0;
                        state_in    = ST_HALF_INIT;
                     end
                  end
                  cdbp_pkg::CMD_END: begin
                     if (pass_ff != cdbp_pkg::PASS_MAX) begin
                        pass_in = pass_ff + cdbp_pkg::PASS_W'(1);
                     end
                  end
                  default: ;
               endcase
            end
         end
         ST_LOAD_RD: begin
            state_in = ST_LOAD_WR;
         end
         ST_LOAD_WR: begin
            state_in = ST_IDLE;
         end
         ST_HALF_INIT: begin
            if (h_empty) begin
               if (half_ff) begin
                  rpar_in  = 1'b0;
                  state_in = ST_SEND;
               end else begin
                  lpar_in  = 1'b0;
                  half_in  = 1'b1;
               end
            end else begin
               cur_in   = h_lo[cdbp_pkg::RANGE_W-1:cdbp_pkg::WORD_LOG];
               first_in = h_lo[cdbp_pkg::RANGE_W-1:cdbp_pkg::WORD_LOG];
               end_in   = h_last[cdbp_pkg::RANGE_W-1:cdbp_pkg::WORD_LOG];
               lob_in   = h_lo[cdbp_pkg::WORD_LOG-1:0];
               hib_in   = h_last[cdbp_pkg::WORD_LOG-1:0];
               acc_in   = 1'b0;
               state_in = ST_WALK;
            end
         end
         ST_WALK: begin
            vld_in  = 1'b1;
            vidx_in = cur_ff;
            if (vld_ff) begin
               acc_in = acc_ff ^ word_par;
            end
            if (cur_ff == end_ff) begin
               state_in = ST_DRAIN;
            end else begin
               cur_in = cur_ff + cdbp_pkg::IDX_W'(1);
            end
         end
         ST_DRAIN: begin
            if (half_ff) begin
               rpar_in  = acc_ff ^ word_par;
               state_in = ST_SEND;
            end else begin
               lpar_in  = acc_ff ^ word_par;
               half_in  = 1'b1;
               state_in = ST_HALF_INIT;
            end
         end
         ST_SEND: begin
            if (!out_valid_ff || rsp_bus.ready) begin
               out_valid_in       = 1'b1;
               out_in.msg_low     = mlo_ff;
               out_in.msg_high    = mhi_ff;
               out_in.left_parity = lpar_ff;
               out_in.right_parity = rpar_ff;
               out_in.pass_number = pass_ff;
               out_in.last_of_run = last_ff;
               if (sec_pend_ff) begin
                  mlo_in      = sec_lo_ff;
                  mhi_in      = sec_hi_ff;
                  last_in     = 1'b1;
                  sec_pend_in = 1'b0;
                  half_in     = 1'b0;
                  state_in    = ST_HALF_INIT;
               end else begin
                  state_in = ST_IDLE;
               end
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         pass_ff      <= '0;
         out_valid_ff <= 1'b0;
         vld_ff       <= 1'b0;
      end else begin
         state_ff     <= state_in;
         pass_ff      <= pass_in;
         out_valid_ff <= out_valid_in;
         vld_ff       <= vld_in;
      end
   end

   // working and payload registers
   always_ff @(posedge clock) begin
      ld_addr_ff  <= ld_addr_in;
      ld_val_ff   <= ld_val_in;
      mlo_ff      <= mlo_in;
      mhi_ff      <= mhi_in;
      sec_lo_ff   <= sec_lo_in;
      sec_hi_ff   <= sec_hi_in;
      last_ff     <= last_in;
      sec_pend_ff <= sec_pend_in;
      half_ff     <= half_in;
      lpar_ff     <= lpar_in;
      rpar_ff     <= rpar_in;
      cur_ff      <= cur_in;
      first_ff    <= first_in;
      end_ff      <= end_in;
      lob_ff      <= lob_in;
      hib_ff      <= hib_in;
      acc_ff      <= acc_in;
      vidx_ff     <= vidx_in;
      out_ff      <= out_in;
   end

   // channel outputs
   assign req_bus.ready = (state_ff == ST_IDLE);
   assign rsp_bus.valid = out_valid_ff;
   assign rsp_bus.data  = out_ff;

endmodule

// ----- sv/cdbp_checker.sv -----
// port-level checks of the dual block parity engine, bound to the top level
module cdbp_checker (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_valid,
   input  logic                      req_ready,
   input  cdbp_pkg::cmd_type         req_cmd,
   input  logic                      rsp_valid,
   input  logic                      rsp_ready,
   input  cdbp_pkg::rsp_payload_type rsp_data
);

   // a stalled response beat stays offered
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid)
      else $error("response beat dropped while stalled");

   // a stalled response beat keeps its payload
   a_rsp_stable: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> $stable(rsp_data))
      else $error("response payload changed while stalled");

   // an open beat starts a parity walk, so the request side closes
   a_open_busy: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready && req_cmd == cdbp_pkg::CMD_OPEN |=> !req_ready)
      else $error("request side open right after an open beat");

   // nothing is offered in the cycle after reset
   a_reset_quiet: assert property (@(posedge clock)
      $past(reset) |-> !rsp_valid)
      else $error("response offered right after reset");

endmodule

bind cascade_dual_block_parity cdbp_checker u_cdbp_checker (
   .clock     (clock),
   .reset     (reset),
   .req_valid (req_bus.valid),
   .req_ready (req_bus.ready),
   .req_cmd   (req_bus.data.cmd),
   .rsp_valid (rsp_bus.valid),
   .rsp_ready (rsp_bus.ready),
   .rsp_data  (rsp_bus.data)
);
